### rtl/spd_pkg.sv
package spd_pkg;

    // Address and history geometry
    localparam int ADDR_WIDTH = 48;
    localparam int HIST_DEPTH = 16;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam int HIDX_W     = $clog2(HIST_DEPTH);

    // Configuration register widths
    localparam int SEQ_W      = 5;
    localparam int LINE_W     = 13;
    localparam int SHIFT_W    = 5;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (FILL_W > SEQ_W) ? FILL_W : SEQ_W;

    // Configuration reset values
    localparam logic [SEQ_W-1:0]   SEQ_RESET   = SEQ_W'(4);
    localparam logic [LINE_W-1:0]  LINE_RESET  = LINE_W'(64);
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(12);
    localparam logic [SEQ_W-1:0]   SEQ_MIN     = SEQ_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEQ_THRESHOLD = 2'd0,
        CFG_LINE_SIZE     = 2'd1,
        CFG_PAGE_SHIFT    = 2'd2,
        CFG_DIRECTION     = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CAUSE_ISSUED   = 2'd0,
        CAUSE_FEW      = 2'd1,
        CAUSE_ORDER    = 2'd2,
        CAUSE_PAGE     = 2'd3
    } t_cause;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq_threshold;
        logic [LINE_W-1:0]  line_size;
        logic [SHIFT_W-1:0] page_shift;
        logic               direction;
    } t_cfg;

    // History view handed to the check stage
    typedef struct packed {
        logic                                  valid;
        logic [FILL_W-1:0]                     fill;
        logic [HIST_DEPTH-1:0][ADDR_WIDTH-1:0] addr;
    } t_hist;

    // Check stage contents handed to the result stage
    typedef struct packed {
        logic                  valid;
        logic                  few;
        logic                  order_ok;
        logic                  wrap;
        logic [ADDR_WIDTH-1:0] fetch;
        logic [ADDR_WIDTH-1:0] start;
    } t_chk;

endpackage

### rtl/spd_if.sv
interface spd_in_if;
    logic                              valid;
    logic                              ready;
    logic [spd_pkg::ADDR_WIDTH-1:0]    load_address;

    modport source (output valid, output load_address, input ready);
    modport sink   (input valid, input load_address, output ready);
endinterface

interface spd_out_if;
    logic                              valid;
    logic                              ready;
    logic                              prefetch_valid;
    logic [spd_pkg::ADDR_WIDTH-1:0]    prefetch_address;
    logic [spd_pkg::ADDR_WIDTH-1:0]    stream_start;
    logic [1:0]                        reject_cause;

    modport source (output valid, output prefetch_valid, output prefetch_address,
                    output stream_start, output reject_cause, input ready);
    modport sink   (input valid, input prefetch_valid, input prefetch_address,
                    input stream_start, input reject_cause, output ready);
endinterface

### rtl/spd_history.sv
module spd_history (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    spd_in_if.sink          in_req,
    output spd_pkg::t_hist  o_hist
);

    logic [spd_pkg::HIST_DEPTH-1:0][spd_pkg::ADDR_WIDTH-1:0] r_addr;
    logic [spd_pkg::FILL_W-1:0]                              r_fill;
    logic                                                    r_valid;
    logic                                                    w_accept;

    // Hold a new request while the previous one waits for the check stage
    assign in_req.ready = !r_valid || i_take;
    assign w_accept     = in_req.valid && in_req.ready;

    // Track the pending item and the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fill  <= '0;
        end else begin
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
            if (w_accept && (r_fill != spd_pkg::FILL_W'(spd_pkg::HIST_DEPTH))) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // Shift the history, newest at entry zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (w_accept) begin
            r_addr <= {r_addr[spd_pkg::HIST_DEPTH-2:0], in_req.load_address};
        end
    end

    assign o_hist.valid = r_valid;
    assign o_hist.fill  = r_fill;
    assign o_hist.addr  = r_addr;

endmodule

### rtl/spd_check.sv
module spd_check (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spd_pkg::t_cfg   i_cfg,
    input  spd_pkg::t_hist  i_hist,
    input  logic            i_adv,
    output logic            o_take,
    output spd_pkg::t_chk   o_chk
);

    logic                                 r_valid;
    logic                                 r_few;
    logic                                 r_order_ok;
    logic                                 r_wrap;
    logic [spd_pkg::ADDR_WIDTH-1:0]       r_fetch;
    logic [spd_pkg::ADDR_WIDTH-1:0]       r_start;

    logic                                 n_few;
    logic                                 n_order_ok;
    logic                                 n_wrap;
    logic [spd_pkg::ADDR_WIDTH-1:0]       n_fetch;
    logic [spd_pkg::ADDR_WIDTH-1:0]       n_start;

    logic [spd_pkg::SEQ_W-1:0]            w_thr;
    logic [spd_pkg::LINE_W:0]             w_window;
    logic [spd_pkg::HIST_DEPTH-1:1]       w_pair_pass;
    logic [spd_pkg::HIDX_W-1:0]           w_start_idx;
    logic [spd_pkg::ADDR_WIDTH:0]         w_sum;
    logic [spd_pkg::ADDR_WIDTH:0]         w_dif;

    assign o_take = !r_valid || i_adv;

    // Clamp the threshold and size the stride window
    assign w_thr    = (i_cfg.seq_threshold < spd_pkg::SEQ_MIN) ? spd_pkg::SEQ_MIN
                                                               : i_cfg.seq_threshold;
    assign w_window = {i_cfg.line_size, 1'b0};

    // Check every adjacent pair in parallel; pairs past the threshold pass
    for (genvar g = 1; g < spd_pkg::HIST_DEPTH; g++) begin : g_pair
        logic [spd_pkg::ADDR_WIDTH:0] w_d;
        logic                         w_ok;
        always_comb begin
            if (i_cfg.direction) begin
                w_d = {1'b0, i_hist.addr[g]} - {1'b0, i_hist.addr[g-1]};
            end else begin
                w_d = {1'b0, i_hist.addr[g-1]} - {1'b0, i_hist.addr[g]};
            end
            w_ok = !w_d[spd_pkg::ADDR_WIDTH]
                && (w_d[spd_pkg::ADDR_WIDTH-1:0]
                    < spd_pkg::ADDR_WIDTH'(w_window));
            w_pair_pass[g] = w_ok || (g >= int'(w_thr));
        end
    end

    // Prefetch candidate one line beyond the newest load
    assign w_sum = {1'b0, i_hist.addr[0]} + (spd_pkg::ADDR_WIDTH + 1)'(i_cfg.line_size);
    assign w_dif = {1'b0, i_hist.addr[0]} - (spd_pkg::ADDR_WIDTH + 1)'(i_cfg.line_size);
    assign w_start_idx = spd_pkg::HIDX_W'(w_thr - 1'b1);

    always_comb begin
        n_few      = spd_pkg::CMP_W'(i_hist.fill) < spd_pkg::CMP_W'(w_thr);
        n_order_ok = &w_pair_pass;
        n_start    = i_hist.addr[w_start_idx];
        if (i_cfg.direction) begin
            n_fetch = w_dif[spd_pkg::ADDR_WIDTH-1:0];
            n_wrap  = w_dif[spd_pkg::ADDR_WIDTH];
        end else begin
            n_fetch = w_sum[spd_pkg::ADDR_WIDTH-1:0];
            n_wrap  = w_sum[spd_pkg::ADDR_WIDTH];
        end
    end

    // Advance the check register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_hist.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_hist.valid) begin
            r_few      <= n_few;
            r_order_ok <= n_order_ok;
            r_wrap     <= n_wrap;
            r_fetch    <= n_fetch;
            r_start    <= n_start;
        end
    end

    assign o_chk.valid    = r_valid;
    assign o_chk.few      = r_few;
    assign o_chk.order_ok = r_order_ok;
    assign o_chk.wrap     = r_wrap;
    assign o_chk.fetch    = r_fetch;
    assign o_chk.start    = r_start;

endmodule

### rtl/spd_result.sv
module spd_result (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  spd_pkg::t_cfg   i_cfg,
    input  spd_pkg::t_chk   i_chk,
    output logic            o_adv,
    spd_out_if.source       out_res
);

    logic                             r_valid;
    logic                             r_pf_valid;
    logic [spd_pkg::ADDR_WIDTH-1:0]   r_pf_addr;
    logic [spd_pkg::ADDR_WIDTH-1:0]   r_start;
    spd_pkg::t_cause                  r_cause;

    logic                             n_pf_valid;
    logic [spd_pkg::ADDR_WIDTH-1:0]   n_pf_addr;
    logic [spd_pkg::ADDR_WIDTH-1:0]   n_start;
    spd_pkg::t_cause                  n_cause;

    logic [spd_pkg::ADDR_WIDTH-1:0]   w_page_mask;
    logic                             w_same_page;

    assign o_adv = !r_valid || out_res.ready;

    // Page compare between the stream start and the prefetch address
    always_comb begin
        if (int'(i_cfg.page_shift) >= spd_pkg::ADDR_WIDTH) begin
            w_page_mask = '0;
        end else begin
            w_page_mask = {spd_pkg::ADDR_WIDTH{1'b1}} << i_cfg.page_shift;
        end
        w_same_page = ((i_chk.start ^ i_chk.fetch) & w_page_mask) == '0;
    end

    // Pick the cause in priority order, zero payload on reject
    always_comb begin
        n_pf_valid = 1'b0;
        n_pf_addr  = '0;
        n_start    = '0;
        priority if (i_chk.few) begin
            n_cause = spd_pkg::CAUSE_FEW;
        end else if (!i_chk.order_ok) begin
            n_cause = spd_pkg::CAUSE_ORDER;
        end else if (i_chk.wrap || !w_same_page) begin
            n_cause = spd_pkg::CAUSE_PAGE;
        end else begin
            n_cause    = spd_pkg::CAUSE_ISSUED;
            n_pf_valid = 1'b1;
            n_pf_addr  = i_chk.fetch;
            n_start    = i_chk.start;
        end
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_chk.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_chk.valid) begin
            r_pf_valid <= n_pf_valid;
            r_pf_addr  <= n_pf_addr;
            r_start    <= n_start;
            r_cause    <= n_cause;
        end
    end

    assign out_res.valid            = r_valid;
    assign out_res.prefetch_valid   = r_pf_valid;
    assign out_res.prefetch_address = r_pf_addr;
    assign out_res.stream_start     = r_start;
    assign out_res.reject_cause     = r_cause;

endmodule

### rtl/stream_prefetch_detector.sv
// Channel   Dir  Payload                                              Handshake
// in_req    in   load_address[47:0]                                   valid/ready
// out_res   out  prefetch_valid, prefetch_address[47:0],              valid/ready
//                stream_start[47:0], reject_cause[1:0]
//
// One load address per cycle sustained while out_res is ready; each request passes through the
// history register, check register and result register before its result is presented.
// Synchronous active-low reset clears the history, fill count and valid flags and loads the configuration reset values.
// A stall on out_res backs up through the check stage; in_req.ready drops only
// when every stage holds an item.
module stream_prefetch_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    spd_in_if.sink                            in_req,
    spd_out_if.source                         out_res
);

    spd_pkg::t_cfg   r_cfg;
    spd_pkg::t_hist  w_hist;
    spd_pkg::t_chk   w_chk;
    logic            w_take;
    logic            w_adv;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_threshold <= spd_pkg::SEQ_RESET;
            r_cfg.line_size     <= spd_pkg::LINE_RESET;
            r_cfg.page_shift    <= spd_pkg::SHIFT_RESET;
            r_cfg.direction     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (spd_pkg::t_cfg_idx'(i_cfg_index))
                spd_pkg::CFG_SEQ_THRESHOLD: begin
                    r_cfg.seq_threshold <= i_cfg_data[spd_pkg::SEQ_W-1:0];
                end
                spd_pkg::CFG_LINE_SIZE: begin
                    r_cfg.line_size <= i_cfg_data[spd_pkg::LINE_W-1:0];
                end
                spd_pkg::CFG_PAGE_SHIFT: begin
                    r_cfg.page_shift <= i_cfg_data[spd_pkg::SHIFT_W-1:0];
                end
                spd_pkg::CFG_DIRECTION: begin
                    r_cfg.direction <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    spd_history u_history (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .in_req  (in_req),
        .o_hist  (w_hist)
    );

    spd_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hist  (w_hist),
        .i_adv   (w_adv),
        .o_take  (w_take),
        .o_chk   (w_chk)
    );

    spd_result u_result (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_chk   (w_chk),
        .o_adv   (w_adv),
        .out_res (out_res)
    );

    // Fill count never passes the history depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hist.fill <= spd_pkg::FILL_W'(spd_pkg::HIST_DEPTH))
        else $error("history fill beyond depth");

    // An accepted request lands as the newest history entry
    a_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_req.valid && in_req.ready) |=> w_hist.valid
            && (w_hist.addr[0] == $past(in_req.load_address)))
        else $error("accepted request missing from history");

    // A pending item that the check stage does not take keeps its history
    a_hist_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hist.valid && !w_take) |=> w_hist.valid && $stable(w_hist.addr))
        else $error("history moved under a stalled item");

    // Rejected results carry no addresses
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_res.valid && (out_res.reject_cause != spd_pkg::CAUSE_ISSUED))
            |-> !out_res.prefetch_valid && (out_res.prefetch_address == '0)
                && (out_res.stream_start == '0))
        else $error("rejected result carries a prefetch");

endmodule

### bench/spd_checker.sv
module spd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [spd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    spd_in_if                              in_req,
    spd_out_if                             out_res,
    output int                             o_fail_count,
    output int                             o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    typedef struct packed {
        logic                  issued;
        logic [ADDR_WIDTH-1:0] fetch;
        logic [ADDR_WIDTH-1:0] start;
        t_cause                cause;
    } t_prefetch;

    logic [ADDR_WIDTH-1:0] load_history [HIST_DEPTH];
    int                    history_count;
    t_cfg                  cfg;
    t_prefetch             predicted_prefetches [$];
    int                    mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    // Record one load and work out the prefetch decision it causes
    function automatic t_prefetch predict_prefetch(input logic [ADDR_WIDTH-1:0] addr);
        t_prefetch             r;
        int                    thr;
        logic [63:0]           window;
        logic [63:0]           newer;
        logic [63:0]           older;
        logic [63:0]           fetch_wide;
        logic [ADDR_WIDTH-1:0] newest;
        logic [ADDR_WIDTH-1:0] start;
        logic [ADDR_WIDTH-1:0] fetch;
        logic                  wrapped;
        logic                  same_page;
        logic                  pair_ok;
        r = '0;
        r.cause = CAUSE_ISSUED;
        for (int i = HIST_DEPTH - 1; i > 0; i--) begin
            load_history[i] = load_history[i-1];
        end
        load_history[0] = addr;
        if (history_count < HIST_DEPTH) begin
            history_count++;
        end
        // A threshold below two still compares one pair
        thr = (cfg.seq_threshold < 2) ? 2 : int'(cfg.seq_threshold);
        if (history_count < thr) begin
            r.cause = CAUSE_FEW;
            return r;
        end
        // Walk the pairs from newest to oldest inside the stride window
        window = 64'(cfg.line_size) * 2;
        for (int i = 1; i < thr; i++) begin
            newer = 64'(load_history[i-1]);
            older = 64'(load_history[i]);
            if (cfg.direction) begin
                pair_ok = (newer <= older) && ((older - newer) < window);
            end else begin
                pair_ok = (newer >= older) && ((newer - older) < window);
            end
            if (!pair_ok) begin
                r.cause = CAUSE_ORDER;
                return r;
            end
        end
        newest = load_history[0];
        start  = load_history[thr-1];
        // One line past the newest load; a carry or borrow counts as a page cross
        if (cfg.direction) begin
            wrapped    = 64'(cfg.line_size) > 64'(newest);
            fetch_wide = 64'(newest) - 64'(cfg.line_size);
        end else begin
            fetch_wide = 64'(newest) + 64'(cfg.line_size);
            wrapped    = |fetch_wide[63:ADDR_WIDTH];
        end
        fetch = fetch_wide[ADDR_WIDTH-1:0];
        if (cfg.page_shift >= ADDR_WIDTH) begin
            same_page = 1'b1;
        end else begin
            same_page = (start >> cfg.page_shift) == (fetch >> cfg.page_shift);
        end
        if (wrapped || !same_page) begin
            r.cause = CAUSE_PAGE;
            return r;
        end
        r.issued = 1'b1;
        r.fetch  = fetch;
        r.start  = start;
        return r;
    endfunction

    // Track register writes, predict on each request, compare each result
    always @(posedge i_clk) begin
        t_prefetch want;
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                load_history[i] = '0;
            end
            history_count = 0;
            cfg = '{SEQ_RESET, LINE_RESET, SHIFT_RESET, 1'b0};
            predicted_prefetches.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEQ_THRESHOLD: cfg.seq_threshold = i_cfg_data[SEQ_W-1:0];
                    CFG_LINE_SIZE:     cfg.line_size     = i_cfg_data[LINE_W-1:0];
                    CFG_PAGE_SHIFT:    cfg.page_shift    = i_cfg_data[SHIFT_W-1:0];
                    CFG_DIRECTION:     cfg.direction     = i_cfg_data[0];
                    default:           ;
                endcase
            end
            if (out_res.valid && out_res.ready) begin
                if (predicted_prefetches.size() == 0) begin
                    $error("result with no request outstanding: cause %0d",
                           out_res.reject_cause);
                    mismatch_total++;
                end else begin
                    want = predicted_prefetches.pop_front();
                    if (out_res.prefetch_valid !== want.issued) begin
                        $error("prefetch_valid: expected %0d, actual %0d",
                               want.issued, out_res.prefetch_valid);
                        mismatch_total++;
                    end
                    if (out_res.prefetch_address !== want.fetch) begin
                        $error("prefetch_address: expected %h, actual %h",
                               want.fetch, out_res.prefetch_address);
                        mismatch_total++;
                    end
                    if (out_res.stream_start !== want.start) begin
                        $error("stream_start: expected %h, actual %h",
                               want.start, out_res.stream_start);
                        mismatch_total++;
                    end
                    if (out_res.reject_cause !== want.cause) begin
                        $error("reject_cause: expected %0d, actual %0d",
                               want.cause, out_res.reject_cause);
                        mismatch_total++;
                    end
                end
            end
            if (in_req.valid && in_req.ready) begin
                predicted_prefetches.push_back(predict_prefetch(in_req.load_address));
            end
        end
        o_pending_count = predicted_prefetches.size();
    end

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 100;
    localparam int DRAIN_TAIL  = 8;

    // What happens halfway through a phase
    localparam int PHASE_PLAIN = 0;
    localparam int PHASE_HOLD  = 1;
    localparam int PHASE_DRAIN = 2;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_BEAT} t_sink_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_total;
    int                    pending_results;

    spd_in_if  load_ch ();
    spd_out_if prefetch_ch ();

    stream_prefetch_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .in_req      (load_ch),
        .out_res     (prefetch_ch)
    );

    spd_checker u_monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .in_req          (load_ch),
        .out_res         (prefetch_ch),
        .o_fail_count    (fail_total),
        .o_pending_count (pending_results)
    );

    // Stream generator state and the settings it shapes streams for
    logic [ADDR_WIDTH-1:0] stream_addr = '0;
    int                    stream_left = 0;
    int                    cur_thr     = 4;
    int                    cur_line    = 64;
    int                    cur_shift   = 12;
    bit                    cur_dir     = 1'b0;
    bit                    gaps_on     = 1'b1;
    int                    burst_left  = 0;
    bit                    hold_req    = 1'b0;

    // Stride, page-cross and wrap cases at reset settings
    logic [ADDR_WIDTH-1:0] directed_loads [19] = '{
        48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF,
        48'h0000_0000_1000, 48'h0000_0000_1000, 48'h0000_0000_1040,
        48'h0000_0000_107F, 48'h0000_0000_10FE, 48'h0000_0000_117E,
        48'h0000_0000_1F80, 48'h0000_0000_1F90, 48'h0000_0000_1FA0,
        48'h0000_0000_1FC0,
        48'hFFFF_FFFF_FFC0, 48'hFFFF_FFFF_FFD0, 48'hFFFF_FFFF_FFE0,
        48'hFFFF_FFFF_FFFF,
        48'hAAAA_5555_AAAA, 48'h5555_AAAA_5555, 48'h5555_AAAA_5515
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [ADDR_WIDTH-1:0] rand_addr();
        return ADDR_WIDTH'({$urandom(), $urandom()});
    endfunction

    // Mostly well-formed streams with random content, some breaks and noise
    function automatic logic [ADDR_WIDTH-1:0] next_load();
        int                    window;
        int                    step;
        logic [ADDR_WIDTH-1:0] pmask;
        window = 2 * cur_line;
        pmask  = (ADDR_WIDTH'(1) << cur_shift) - 1;
        if (stream_left == 0) begin
            stream_left = $urandom_range(1, cur_thr + 8);
            case ($urandom_range(0, 7))
                0: stream_addr = {ADDR_WIDTH{1'b1}} - ADDR_WIDTH'($urandom_range(0, 4 * cur_line));
                1: stream_addr = ADDR_WIDTH'($urandom_range(0, 4 * cur_line));
                2: begin
                    if (cur_dir) begin
                        stream_addr = (rand_addr() & ~pmask)
                                      + ADDR_WIDTH'($urandom_range(0, 2 * cur_line));
                    end else begin
                        stream_addr = (rand_addr() | pmask)
                                      - ADDR_WIDTH'($urandom_range(0, 2 * cur_line));
                    end
                end
                default: stream_addr = rand_addr();
            endcase
        end else begin
            case ($urandom_range(0, 15))
                0:       step = window;
                1:       step = (window > 0) ? window - 1 : 0;
                2:       step = 0;
                3:       begin
                    stream_addr = rand_addr();
                    step = 0;
                end
                4:       step = -$urandom_range(1, window + 1);
                default: step = (window > 0) ? $urandom_range(0, window - 1) : 0;
            endcase
            if (cur_dir) begin
                stream_addr = stream_addr - ADDR_WIDTH'(step);
            end else begin
                stream_addr = stream_addr + ADDR_WIDTH'(step);
            end
        end
        stream_left--;
        return stream_addr;
    endfunction

    // Offer one request in bursts with random gaps; return at a falling edge
    task automatic send_load(input logic [ADDR_WIDTH-1:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                load_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        load_ch.valid        <= 1'b1;
        load_ch.load_address <= addr;
        @(posedge i_clk);
        while (!load_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Drop valid and hold until every result is back
    task automatic drain_results();
        load_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending_results != 0);
    endtask

    task automatic write_config(input int seq, input int line, input int shift, input bit dir);
        logic [CFG_DATA_W-1:0] d;
        cfg_we    <= 1'b1;
        d = CFG_DATA_W'($urandom());
        d[SEQ_W-1:0] = SEQ_W'(seq);
        cfg_index <= CFG_SEQ_THRESHOLD;
        cfg_data  <= d;
        @(negedge i_clk);
        cfg_index <= CFG_LINE_SIZE;
        cfg_data  <= CFG_DATA_W'(line);
        @(negedge i_clk);
        d = CFG_DATA_W'($urandom());
        d[SHIFT_W-1:0] = SHIFT_W'(shift);
        cfg_index <= CFG_PAGE_SHIFT;
        cfg_data  <= d;
        @(negedge i_clk);
        d = CFG_DATA_W'($urandom());
        d[0] = dir;
        cfg_index <= CFG_DIRECTION;
        cfg_data  <= d;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        cur_thr   = (seq < 2) ? 2 : seq;
        cur_line  = line;
        cur_shift = shift;
        cur_dir   = dir;
    endtask

    task automatic run_phase(input int seq, input int line, input int shift, input bit dir,
                             input int n_items, input int midway);
        drain_results();
        repeat (4) @(negedge i_clk);
        write_config(seq, line, shift, dir);
        stream_left = 0;
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int k = 0; k < n_items; k++) begin
            if (k == n_items / 2 && midway == PHASE_HOLD) begin
                gaps_on  = 1'b0;
                hold_req = 1'b1;
            end
            if (k == n_items / 2 && midway == PHASE_DRAIN) begin
                drain_results();
            end
            send_load(next_load());
        end
    endtask

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin : result_sink
        t_sink_mode mode;
        int         left;
        int         tick;
        mode = SINK_OPEN;
        left = 0;
        tick = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                prefetch_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    left = $urandom_range(20, 200);
                end
                left--;
                tick++;
                case (mode)
                    SINK_OPEN: prefetch_ch.ready <= 1'b1;
                    SINK_COIN: prefetch_ch.ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW: prefetch_ch.ready <= ($urandom_range(0, 3) == 0);
                    SINK_BEAT: prefetch_ch.ready <= (tick % 5 != 0);
                    default:   prefetch_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((load_ch.valid && load_ch.ready) || (prefetch_ch.valid && prefetch_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_SEQ_THRESHOLD;
        cfg_data             = '0;
        load_ch.valid        = 1'b0;
        load_ch.load_address = '0;
        prefetch_ch.ready    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_loads[i]) begin
            send_load(directed_loads[i]);
        end

        run_phase(4, 64, 12, 1'b0, 120, PHASE_PLAIN);
        run_phase(2, 1, 12, 1'b0, 120, PHASE_DRAIN);
        run_phase(16, 4096, 30, 1'b1, 120, PHASE_PLAIN);
        run_phase(0, 64, 12, 1'b1, 100, PHASE_PLAIN);
        run_phase(1, 32, 13, 1'b0, 100, PHASE_PLAIN);
        // threshold past the history depth never finds enough loads
        run_phase(17, 64, 12, 1'b0, 60, PHASE_PLAIN);
        run_phase(31, 128, 31, 1'b1, 40, PHASE_PLAIN);
        // zero line size fails every stride check
        run_phase(6, 0, 12, 1'b0, 80, PHASE_PLAIN);
        run_phase(3, 4096, 12, 1'b1, 120, PHASE_PLAIN);
        run_phase(16, 64, 12, 1'b0, 150, PHASE_HOLD);
        for (int p = 0; p < 4; p++) begin
            run_phase($urandom_range(0, 16), $urandom_range(1, 4096), $urandom_range(12, 31),
                      1'($urandom_range(0, 1)), 120, PHASE_PLAIN);
        end

        drain_results();
        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (fail_total == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### stream_prefetch_detector.f
rtl/spd_pkg.sv
rtl/spd_if.sv
rtl/spd_history.sv
rtl/spd_check.sv
rtl/spd_result.sv
rtl/stream_prefetch_detector.sv
bench/spd_checker.sv
bench/tb.sv
